FILE: design/lat_pkg.sv
// Shared types and constants of the labeled arc transition table.
`default_nettype none
package lat_pkg;

   localparam int MAX_STATES  = 16;  // fixed by the 4-bit state fields
   localparam int STATE_W     = 4;
   localparam int CFG_W       = 5;
   localparam int SYM_IN_W    = 8;
   localparam int SYM_WIDE_W  = 16;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_EXISTS = 2'd2,
      CMD_TRANS  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [STATE_W-1:0] reached;
   } result_type;

   localparam logic [0:0] CSR_IDX_STATES = 1'b0;

endpackage
`default_nettype wire

FILE: design/lat_slot_ram.sv
// Arc slot memory: one write port, one read port, registered read data.
`default_nettype none
module lat_slot_ram #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 12,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: design/lat_ctrl.sv
// Command sequencer: list scan, slot shifting and per-state arc counts.
`default_nettype none
module lat_ctrl #(
   parameter int ARCS_PER_STATE = 8,
   parameter int SYMBOL_BITS    = 8,
   parameter int IDX_W          = 3,
   parameter int CNT_W          = 4,
   parameter int ADDR_W         = 7,
   parameter int ENTRY_W        = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire lat_pkg::cmd_type             req_cmd,
   input  wire logic [lat_pkg::STATE_W-1:0]  req_src,
   input  wire logic [lat_pkg::STATE_W-1:0]  req_dst,
   input  wire logic [SYMBOL_BITS-1:0]       req_sym,
   input  wire logic [lat_pkg::CFG_W-1:0]    states_in_use,
   input  wire logic                         out_free,
   output logic                              done,
   output lat_pkg::result_type               result,
   output logic                              ram_wr_en,
   output logic [ADDR_W-1:0]                 ram_wr_addr,
   output logic [ENTRY_W-1:0]                ram_wr_data,
   output logic                              ram_rd_en,
   output logic [ADDR_W-1:0]                 ram_rd_addr,
   input  wire logic [ENTRY_W-1:0]           ram_rd_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_MOVE   = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_WRNEW  = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   lat_pkg::cmd_type              cmd_ff, cmd_in;
   logic [lat_pkg::STATE_W-1:0]   src_ff, src_in;
   logic [lat_pkg::STATE_W-1:0]   dst_ff, dst_in;
   logic [SYMBOL_BITS-1:0]        sym_ff, sym_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [CNT_W-1:0]              iss_ff, iss_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          hit_ff, hit_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [lat_pkg::STATE_W-1:0]   reach_ff, reach_in;
   logic [IDX_W-1:0]              mv_ff, mv_in;
   logic                          wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]              wr_idx_ff, wr_idx_in;
   lat_pkg::result_type           res_ff, res_in;

   logic [CNT_W-1:0]              counts_ff [lat_pkg::MAX_STATES];
   logic                          cnt_we;
   logic [CNT_W-1:0]              cnt_wval;

   logic [IDX_W-1:0]              rd_idx;
   logic [CNT_W-1:0]              cnt_m1;
   logic [SYMBOL_BITS-1:0]        rd_sym;
   logic [lat_pkg::STATE_W-1:0]   rd_dest;
   logic                          match;
   logic [ADDR_W-1:0]             base;
   logic                          new_wr;

   assign rd_sym  = ram_rd_data[SYMBOL_BITS-1:0];
   assign rd_dest = ram_rd_data[SYMBOL_BITS +: lat_pkg::STATE_W];
   assign match   = (rd_sym == sym_ff) &&
                    ((cmd_ff == lat_pkg::CMD_TRANS) || (rd_dest == dst_ff));
   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign base    = ADDR_W'(src_ff) * ADDR_W'(ARCS_PER_STATE);

   // write port: a shifted slot lands in the cycle after its read; new arc goes in alone
   assign new_wr      = (state_ff == S_WRNEW);
   assign ram_wr_en   = wr_pend_ff | new_wr;
   assign ram_wr_addr = base + ADDR_W'(wr_pend_ff ? wr_idx_ff : '0);
   assign ram_wr_data = wr_pend_ff ? ram_rd_data : {dst_ff, sym_ff};
   assign ram_rd_addr = base + ADDR_W'(rd_idx);

   assign req_ready = (state_ff == S_IDLE);
   assign result    = res_ff;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      sym_in     = sym_ff;
      cnt_in     = cnt_ff;
      iss_in     = iss_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      hit_in     = hit_ff;
      pos_in     = pos_ff;
      reach_in   = reach_ff;
      mv_in      = mv_ff;
      wr_pend_in = 1'b0;
      wr_idx_in  = wr_idx_ff;
      res_in     = res_ff;
      cnt_we     = 1'b0;
      cnt_wval   = cnt_ff;
      ram_rd_en  = 1'b0;
      rd_idx     = '0;
      done       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               src_in = req_src;
               dst_in = req_dst;
               sym_in = req_sym;
               cnt_in = counts_ff[req_src];
               iss_in = '0;
               hit_in = 1'b0;
               if (lat_pkg::CFG_W'(req_src) >= states_in_use) begin
                  res_in   = '{lat_pkg::ST_RANGE, 1'b0, '0};
                  state_in = S_FIN;
               end else if (counts_ff[req_src] == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // reads issue one slot a cycle; compare runs in the cycle after each read
            if (iss_ff < cnt_ff) begin
               ram_rd_en  = 1'b1;
               rd_idx     = iss_ff[IDX_W-1:0];
               iss_in     = iss_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (match) begin
                  hit_in     = 1'b1;
                  pos_in     = chk_idx_ff;
                  reach_in   = rd_dest;
                  chk_vld_in = 1'b0;
                  state_in   = S_DECIDE;
               end else if (CNT_W'(chk_idx_ff) == cnt_m1) begin
                  chk_vld_in = 1'b0;
                  state_in   = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            case (cmd_ff)
               lat_pkg::CMD_ADD: begin
                  if (hit_ff) begin
                     res_in   = '{lat_pkg::ST_DUP, 1'b1, '0};
                     state_in = S_FIN;
                  end else if (cnt_ff == CNT_W'(ARCS_PER_STATE)) begin
                     res_in   = '{lat_pkg::ST_FULL, 1'b0, '0};
                     state_in = S_FIN;
                  end else begin
                     res_in = '{lat_pkg::ST_OK, 1'b0, '0};
                     if (cnt_ff == '0) begin
                        state_in = S_WRNEW;
                     end else begin
                        mv_in    = cnt_m1[IDX_W-1:0];
                        state_in = S_MOVE;
                     end
                  end
               end
               lat_pkg::CMD_REMOVE: begin
                  if (!hit_ff) begin
                     res_in   = '{lat_pkg::ST_NOTFOUND, 1'b0, '0};
                     state_in = S_FIN;
                  end else begin
                     res_in   = '{lat_pkg::ST_OK, 1'b1, '0};
                     cnt_we   = 1'b1;
                     cnt_wval = cnt_m1;
                     if (CNT_W'(pos_ff) < cnt_m1) begin
                        mv_in    = pos_ff + IDX_W'(1);
                        state_in = S_MOVE;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
               end
               lat_pkg::CMD_EXISTS: begin
                  if (hit_ff) begin
                     res_in = '{lat_pkg::ST_OK, 1'b1, '0};
                  end else begin
                     res_in = '{lat_pkg::ST_NOTFOUND, 1'b0, '0};
                  end
                  state_in = S_FIN;
               end
               default: begin
                  if (hit_ff) begin
                     res_in = '{lat_pkg::ST_OK, 1'b1, reach_ff};
                  end else begin
                     res_in = '{lat_pkg::ST_NOTFOUND, 1'b0, '0};
                  end
                  state_in = S_FIN;
               end
            endcase
         end
         S_MOVE: begin
            // add: walk down, slot i moves to i+1; remove: walk up, i moves to i-1
            ram_rd_en  = 1'b1;
            rd_idx     = mv_ff;
            wr_pend_in = 1'b1;
            if (cmd_ff == lat_pkg::CMD_ADD) begin
               wr_idx_in = mv_ff + IDX_W'(1);
               if (mv_ff == '0) begin
                  state_in = S_DRAIN;
               end else begin
                  mv_in = mv_ff - IDX_W'(1);
               end
            end else begin
               wr_idx_in = mv_ff - IDX_W'(1);
               if (CNT_W'(mv_ff) == cnt_m1) begin
                  state_in = S_DRAIN;
               end else begin
                  mv_in = mv_ff + IDX_W'(1);
               end
            end
         end
         S_DRAIN: begin
            if (cmd_ff == lat_pkg::CMD_ADD) begin
               state_in = S_WRNEW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WRNEW: begin
            cnt_we   = 1'b1;
            cnt_wval = cnt_ff + CNT_W'(1);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         wr_pend_ff <= 1'b0;
         for (int i = 0; i < lat_pkg::MAX_STATES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         wr_pend_ff <= wr_pend_in;
         if (cnt_we) begin
            counts_ff[src_ff] <= cnt_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      sym_ff     <= sym_in;
      cnt_ff     <= cnt_in;
      iss_ff     <= iss_in;
      chk_idx_ff <= chk_idx_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      reach_ff   <= reach_in;
      mv_ff      <= mv_in;
      wr_idx_ff  <= wr_idx_in;
      res_ff     <= res_in;
   end

`ifndef SYNTHESIS
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && (state_ff == S_WRNEW)))
      else $error("shifted slot and new arc collide on the write port");

   a_chk_in_list: assert property (@(posedge clock) disable iff (reset)
      (chk_vld_ff && (state_ff == S_SCAN)) |-> (CNT_W'(chk_idx_ff) < cnt_ff))
      else $error("scan compared a slot beyond the list");

   a_move_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |=> wr_pend_ff)
      else $error("slot read during shift not written back");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (req_ready && !wr_pend_ff))
      else $error("item finished with work still pending");
`endif

endmodule
`default_nettype wire

FILE: design/labeled_arc_transition_table_top.sv
// Top level of the labeled arc transition table: CSR, stream ports, result register.
//
// Usage
//   req_*  : one command item per handshake (tvalid & tready). tuser carries the
//            command (add, remove, exists, transition); tdata carries source state,
//            destination state and symbol.
//   rsp_*  : exactly one result item per command: status, arc found flag and the
//            reached state of a transition.
//   csr_*  : APB-style port, register 0 (byte address 0) is states_in_use.
//            Write it only while the block is idle.
// Sequencing
//   One item at a time: the next item is taken only after this one's result has
//   gone into the output register, and the result shows on rsp_* from the first
//   cycle in which the next item can be taken. A state out of range is not
//   scanned, nor is an empty list. The scan reads one slot a cycle and compares
//   each slot as its data arrives from the memory. The shift of an add or remove
//   reads one slot and writes the previously read one in the same cycle; an add
//   then writes the new arc into slot 0.
// Stalls
//   The result sits in an output register; while it waits the next item is
//   still accepted and worked on, and only its own result waits for the slot.
// Reset
//   Clears all list counts and sets states_in_use to 16. Slot contents are not
//   cleared: a slot is only read once it lies inside its list.
`default_nettype none
module labeled_arc_transition_table_top #(
   parameter int ARCS_PER_STATE = 8,
   parameter int SYMBOL_BITS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [3:0] source_state, [7:4] dest_state, [15:8] symbol
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   // result item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [2:0] status, [3] arc_found, [7:4] reached_state
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_W   = (ARCS_PER_STATE > 1) ? $clog2(ARCS_PER_STATE) : 1;
   localparam int CNT_W   = $clog2(ARCS_PER_STATE + 1);
   localparam int DEPTH   = lat_pkg::MAX_STATES * ARCS_PER_STATE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = lat_pkg::STATE_W + SYMBOL_BITS;

   // configuration register
   logic [lat_pkg::CFG_W-1:0] states_ff, states_in;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      states_in = states_ff;
      if (csr_wr && (csr_paddr[2] == lat_pkg::CSR_IDX_STATES)) begin
         states_in = csr_pwdata[lat_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lat_pkg::CSR_IDX_STATES) begin
         csr_prdata = 32'(states_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff <= lat_pkg::CFG_W'(lat_pkg::MAX_STATES);
      end else begin
         states_ff <= states_in;
      end
   end

   // input unpacking; symbol bits above SYMBOL_BITS are dropped
   logic [lat_pkg::SYM_WIDE_W-1:0] sym_wide;
   logic [SYMBOL_BITS-1:0]         sym;

   assign sym_wide = lat_pkg::SYM_WIDE_W'(req_tdata[15:8]);
   assign sym      = sym_wide[SYMBOL_BITS-1:0];

   // result register parts the sequencer from the output stall
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;
   logic                out_free;
   logic                done;
   lat_pkg::result_type result;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {result.reached, result.found, result.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer and slot memory
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   lat_ctrl #(
      .ARCS_PER_STATE (ARCS_PER_STATE),
      .SYMBOL_BITS    (SYMBOL_BITS),
      .IDX_W          (IDX_W),
      .CNT_W          (CNT_W),
      .ADDR_W         (ADDR_W),
      .ENTRY_W        (ENTRY_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_cmd       (lat_pkg::cmd_type'(req_tuser)),
      .req_src       (req_tdata[3:0]),
      .req_dst       (req_tdata[7:4]),
      .req_sym       (sym),
      .states_in_use (states_ff),
      .out_free      (out_free),
      .done          (done),
      .result        (result),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   lat_slot_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire
